FILE: src/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the triangle tangent block
// Vertex, job and status types, fixed widths and the output scaling.
// ----------------------------------------------------------------------------
package ttb_pkg;

    // input field widths
    localparam int COORD_W = 16;
    localparam int TEX_W   = 16;

    // edges and UV deltas: exact differences of two 16-bit values
    localparam int EDGE_W  = COORD_W + 1;
    // products of two deltas
    localparam int PROD_W  = 2 * EDGE_W;
    // numerators and determinant: difference of two products
    localparam int NUM_W   = PROD_W + 1;
    // magnitudes stay below 2^33
    localparam int ABS_W   = NUM_W - 1;

    // output format
    localparam int OUT_W         = 32;
    localparam int OUT_FRAC_BITS = 16;
    // numerators carry 27 fraction bits, det 30
    localparam int SHIFT         = 3 + OUT_FRAC_BITS;

    // quotient bits kept below the overflow check
    localparam int QB      = OUT_W + 1;
    localparam int A_W     = ABS_W + SHIFT;
    localparam int HI_W    = A_W - QB;
    localparam int CNT_W   = $clog2(QB + 1);
    // multiplier sequence: det step, three component steps, one drain step
    localparam int MUL_LAST = 4;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // corner numbering
    localparam logic [1:0] CORNER_LAST = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [NUM_W-1:0]   num_t;

    typedef struct packed {
        coord_t [2:0]     pos;
        logic [TEX_W-1:0] u;
        logic [TEX_W-1:0] v;
    } vertex_t;

    typedef struct packed {
        edge_t [2:0] e1;
        edge_t [2:0] e2;
        edge_t       du1;
        edge_t       dv1;
        edge_t       du2;
        edge_t       dv2;
    } job_t;

    typedef struct packed {
        logic [1:0] corner_cnt;
        logic       push;
    } front_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

FILE: src/triangle_tangent_bitangent.sv
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent: per-triangle tangent and bitangent from UVs
// The solver takes one triangle at a time: a 33-step radix-2 division,
// shared in step by six divider lanes, follows the products and is skipped
// for a zero det; a two-entry job queue lets vertex intake run ahead of the
// solver. Reset clears the corner count, the queue and the solver state;
// held corners are undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  pos_x,
    input  logic signed [15:0]  pos_y,
    input  logic signed [15:0]  pos_z,
    input  logic [15:0]         tex_u,
    input  logic [15:0]         tex_v,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  tangent_x,
    output logic signed [31:0]  tangent_y,
    output logic signed [31:0]  tangent_z,
    output logic signed [31:0]  bitangent_x,
    output logic signed [31:0]  bitangent_y,
    output logic signed [31:0]  bitangent_z,
    output logic                degenerate
);

    ttb_pkg::vertex_t            vtx;
    ttb_pkg::job_t               fr_job, q_job;
    ttb_pkg::front_stat_t        fst;
    logic                        fr_valid, fr_ready;
    logic                        q_valid, q_ready;
    logic                        back_busy;
    logic [ttb_pkg::OUT_W-1:0]   tan_out [3];
    logic [ttb_pkg::OUT_W-1:0]   bit_out [3];

    assign vtx.pos[0] = pos_x;
    assign vtx.pos[1] = pos_y;
    assign vtx.pos[2] = pos_z;
    assign vtx.u      = tex_u;
    assign vtx.v      = tex_v;

    ttb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vtx       (vtx),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job),
        .stat      (fst)
    );

    ttb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    ttb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tan_out   (tan_out),
        .bit_out   (bit_out),
        .deg_out   (degenerate),
        .busy      (back_busy)
    );

    assign tangent_x   = tan_out[0];
    assign tangent_y   = tan_out[1];
    assign tangent_z   = tan_out[2];
    assign bitangent_x = bit_out[0];
    assign bitangent_y = bit_out[1];
    assign bitangent_z = bit_out[2];

    // only the closing corner of a triangle hands a job to the queue
    a_push_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        fst.push |-> (fst.corner_cnt == ttb_pkg::CORNER_LAST) && in_valid && in_ready)
        else $error("job pushed on a non-final corner");

    // a result only appears after the solver has worked on a job
    a_result_from_solver: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_busy))
        else $error("result without solver activity");

    // degenerate triangles carry zero vectors
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |->
            (tangent_x == 0) && (tangent_y == 0) && (tangent_z == 0) &&
            (bitangent_x == 0) && (bitangent_y == 0) && (bitangent_z == 0))
        else $error("degenerate result with nonzero vectors");

endmodule

FILE: src/ttb_queue.sv
// ----------------------------------------------------------------------------
// ttb_queue: short job queue
// Two-entry FIFO of triangle jobs between the front and the back end.
// ----------------------------------------------------------------------------
module ttb_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ttb_pkg::job_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ttb_pkg::job_t  pop_data
);

    ttb_pkg::job_t                 mem_reg [ttb_pkg::Q_DEPTH];
    logic [ttb_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ttb_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ttb_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    assign push_ready = (count_reg != ttb_pkg::Q_CNT_W'(ttb_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == ttb_pkg::Q_PTR_W'(ttb_pkg::Q_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + ttb_pkg::Q_PTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == ttb_pkg::Q_PTR_W'(ttb_pkg::Q_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + ttb_pkg::Q_PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + ttb_pkg::Q_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - ttb_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: src/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front: vertex intake
// Counts corners, holds corners 0 and 1, and on corner 2 forms the edges
// and UV deltas of the triangle as one job for the back end.
// ----------------------------------------------------------------------------
module ttb_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ttb_pkg::vertex_t             vtx,
    output logic                         job_valid,
    input  logic                         job_ready,
    output ttb_pkg::job_t                job,
    output ttb_pkg::front_stat_t         stat
);

    logic [1:0]       count_reg, count_next;
    ttb_pkg::vertex_t c0_reg, c1_reg;
    logic             xfer;
    logic             last;

    assign last      = (count_reg == ttb_pkg::CORNER_LAST);
    assign in_ready  = !last || job_ready;
    assign job_valid = in_valid && last;
    assign xfer      = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job.e1[i] = ttb_pkg::edge_t'(c0_reg.pos[i]) - ttb_pkg::edge_t'(c1_reg.pos[i]);
            job.e2[i] = ttb_pkg::edge_t'(c0_reg.pos[i]) - ttb_pkg::edge_t'(vtx.pos[i]);
        end
        job.du1 = ttb_pkg::edge_t'({1'b0, c0_reg.u}) - ttb_pkg::edge_t'({1'b0, c1_reg.u});
        job.dv1 = ttb_pkg::edge_t'({1'b0, c0_reg.v}) - ttb_pkg::edge_t'({1'b0, c1_reg.v});
        job.du2 = ttb_pkg::edge_t'({1'b0, c0_reg.u}) - ttb_pkg::edge_t'({1'b0, vtx.u});
        job.dv2 = ttb_pkg::edge_t'({1'b0, c0_reg.v}) - ttb_pkg::edge_t'({1'b0, vtx.v});
    end

    always_comb
    begin
        count_next = count_reg;
        if (xfer)
        begin
            if (last)
                count_next = 2'd0;
            else
                count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (xfer && (count_reg == 2'd0))
            c0_reg <= vtx;
        if (xfer && (count_reg == 2'd1))
            c1_reg <= vtx;
    end

    assign stat.corner_cnt = count_reg;
    assign stat.push       = job_valid && job_ready;

endmodule

FILE: src/ttb_div_lane.sv
// ----------------------------------------------------------------------------
// ttb_div_lane: scaled divider lane
// Radix-2 restoring division of |num| << SHIFT by |det|, one quotient bit
// per step, then round half away from zero and saturate to 32 bits.
// ----------------------------------------------------------------------------
module ttb_div_lane
(
    input  logic                          clk,
    input  logic                          load,
    input  logic                          step,
    input  ttb_pkg::num_t                 num,
    input  logic                          den_neg,
    input  logic [ttb_pkg::ABS_W-1:0]     den,
    output logic [ttb_pkg::OUT_W-1:0]     result
);

    logic [ttb_pkg::ABS_W-1:0] rem_reg, rem_next;
    logic [ttb_pkg::QB-1:0]    low_reg, low_next;
    logic [ttb_pkg::QB-1:0]    q_reg, q_next;
    logic                      neg_reg, neg_next;
    logic                      ovf_reg, ovf_next;

    logic [ttb_pkg::ABS_W-1:0] num_mag;
    logic [ttb_pkg::A_W-1:0]   a_full;
    logic [ttb_pkg::HI_W-1:0]  a_hi;
    logic [ttb_pkg::ABS_W:0]   trial;
    logic                      ge;
    logic                      rnd;
    logic [ttb_pkg::QB:0]      q_rnd;

    always_comb
    begin
        if (num[ttb_pkg::NUM_W-1])
            num_mag = ttb_pkg::ABS_W'(-num);
        else
            num_mag = ttb_pkg::ABS_W'(num);
        a_full = ttb_pkg::A_W'(num_mag) << ttb_pkg::SHIFT;
        a_hi   = a_full[ttb_pkg::A_W-1:ttb_pkg::QB];
        trial  = {rem_reg, low_reg[ttb_pkg::QB-1]};
        ge     = (trial >= {1'b0, den});

        rem_next = rem_reg;
        low_next = low_reg;
        q_next   = q_reg;
        neg_next = neg_reg;
        ovf_next = ovf_reg;
        if (load)
        begin
            rem_next = ttb_pkg::ABS_W'(a_hi);
            low_next = a_full[ttb_pkg::QB-1:0];
            q_next   = '0;
            neg_next = num[ttb_pkg::NUM_W-1] ^ den_neg;
            // quotient of 2^QB or more always saturates
            ovf_next = (ttb_pkg::ABS_W'(a_hi) >= den);
        end
        else if (step)
        begin
            if (ge)
                rem_next = ttb_pkg::ABS_W'(trial - {1'b0, den});
            else
                rem_next = ttb_pkg::ABS_W'(trial);
            low_next = {low_reg[ttb_pkg::QB-2:0], 1'b0};
            q_next   = {q_reg[ttb_pkg::QB-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

    // half or more of the divisor left over rounds the magnitude up
    always_comb
    begin
        rnd   = ({rem_reg, 1'b0} >= {1'b0, den});
        q_rnd = {1'b0, q_reg} + (ttb_pkg::QB + 1)'(rnd);
        if (neg_reg)
        begin
            if (ovf_reg || (q_rnd > (ttb_pkg::QB + 1)'(ttb_pkg::OUT_MIN)))
                result = ttb_pkg::OUT_MIN;
            else
                result = -q_rnd[ttb_pkg::OUT_W-1:0];
        end
        else
        begin
            if (ovf_reg || (q_rnd > (ttb_pkg::QB + 1)'(ttb_pkg::OUT_MAX)))
                result = ttb_pkg::OUT_MAX;
            else
                result = q_rnd[ttb_pkg::OUT_W-1:0];
        end
    end

endmodule

FILE: src/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back: tangent solver
// Sequences four multipliers over the determinant and the six numerators,
// runs six divider lanes in step and holds the result in an output register.
// ----------------------------------------------------------------------------
module ttb_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  ttb_pkg::job_t                 job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttb_pkg::OUT_W-1:0]     tan_out [3],
    output logic [ttb_pkg::OUT_W-1:0]     bit_out [3],
    output logic                          deg_out,
    output logic                          busy
);

    ttb_pkg::back_state_t      state_reg, state_next;
    logic [ttb_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    ttb_pkg::job_t   job_reg;
    ttb_pkg::prod_t  p0_reg, p1_reg, p2_reg, p3_reg;
    ttb_pkg::num_t   det_reg;
    ttb_pkg::num_t   tnum_reg [3];
    ttb_pkg::num_t   bnum_reg [3];

    logic [ttb_pkg::OUT_W-1:0] tan_reg [3];
    logic [ttb_pkg::OUT_W-1:0] bit_reg [3];
    logic                      deg_reg;
    logic                      out_valid_reg;

    logic [ttb_pkg::OUT_W-1:0] tan_res [3];
    logic [ttb_pkg::OUT_W-1:0] bit_res [3];

    logic                      take_job, lane_load, lane_step, out_load, out_free;
    logic                      det_zero;
    logic [ttb_pkg::ABS_W-1:0] den_mag;
    ttb_pkg::edge_t            sel_e1, sel_e2;
    ttb_pkg::edge_t            m0_a, m1_a;

    assign out_free = !out_valid_reg || out_ready;
    assign det_zero = (det_reg == '0);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ttb_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ttb_pkg::BK_MUL;
                    cnt_next   = '0;
                end
            end
            ttb_pkg::BK_MUL:
            begin
                if (cnt_reg == ttb_pkg::CNT_W'(ttb_pkg::MUL_LAST))
                begin
                    cnt_next = '0;
                    if (det_zero)
                        state_next = ttb_pkg::BK_DONE;
                    else
                        state_next = ttb_pkg::BK_DIV;
                end
                else
                    cnt_next = cnt_reg + ttb_pkg::CNT_W'(1);
            end
            ttb_pkg::BK_DIV:
            begin
                if (cnt_reg == ttb_pkg::CNT_W'(ttb_pkg::QB))
                    state_next = ttb_pkg::BK_DONE;
                else
                    cnt_next = cnt_reg + ttb_pkg::CNT_W'(1);
            end
            ttb_pkg::BK_DONE:
            begin
                if (out_free)
                    state_next = ttb_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = ttb_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        take_job  = 1'b0;
        lane_load = 1'b0;
        lane_step = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ttb_pkg::BK_IDLE: take_job = job_valid;
            ttb_pkg::BK_DIV:
            begin
                lane_load = (cnt_reg == '0);
                lane_step = (cnt_reg != '0);
            end
            ttb_pkg::BK_DONE: out_load = out_free;
            default:
            begin
                take_job = 1'b0;
            end
        endcase
    end

    assign job_ready = take_job;
    assign busy      = (state_reg != ttb_pkg::BK_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttb_pkg::BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- multiplier sequence ----------------
    // step 0: det products; steps 1..3: products of component 0..2
    always_comb
    begin
        case (cnt_reg)
            ttb_pkg::CNT_W'(2):
            begin
                sel_e1 = job_reg.e1[1];
                sel_e2 = job_reg.e2[1];
            end
            ttb_pkg::CNT_W'(3):
            begin
                sel_e1 = job_reg.e1[2];
                sel_e2 = job_reg.e2[2];
            end
            default:
            begin
                sel_e1 = job_reg.e1[0];
                sel_e2 = job_reg.e2[0];
            end
        endcase
        if (cnt_reg == '0)
        begin
            m0_a = job_reg.du1;
            m1_a = job_reg.du2;
        end
        else
        begin
            m0_a = sel_e1;
            m1_a = sel_e2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_job)
            job_reg <= job;
        if (state_reg == ttb_pkg::BK_MUL)
        begin
            p0_reg <= ttb_pkg::prod_t'(m0_a) * ttb_pkg::prod_t'(job_reg.dv2);
            p1_reg <= ttb_pkg::prod_t'(m1_a) * ttb_pkg::prod_t'(job_reg.dv1);
            p2_reg <= ttb_pkg::prod_t'(job_reg.du1) * ttb_pkg::prod_t'(sel_e2);
            p3_reg <= ttb_pkg::prod_t'(job_reg.du2) * ttb_pkg::prod_t'(sel_e1);
            case (cnt_reg)
                ttb_pkg::CNT_W'(1):
                    det_reg <= ttb_pkg::num_t'(p0_reg) - ttb_pkg::num_t'(p1_reg);
                ttb_pkg::CNT_W'(2):
                begin
                    tnum_reg[0] <= ttb_pkg::num_t'(p0_reg) - ttb_pkg::num_t'(p1_reg);
                    bnum_reg[0] <= ttb_pkg::num_t'(p2_reg) - ttb_pkg::num_t'(p3_reg);
                end
                ttb_pkg::CNT_W'(3):
                begin
                    tnum_reg[1] <= ttb_pkg::num_t'(p0_reg) - ttb_pkg::num_t'(p1_reg);
                    bnum_reg[1] <= ttb_pkg::num_t'(p2_reg) - ttb_pkg::num_t'(p3_reg);
                end
                ttb_pkg::CNT_W'(4):
                begin
                    tnum_reg[2] <= ttb_pkg::num_t'(p0_reg) - ttb_pkg::num_t'(p1_reg);
                    bnum_reg[2] <= ttb_pkg::num_t'(p2_reg) - ttb_pkg::num_t'(p3_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- divider lanes ----------------
    always_comb
    begin
        if (det_reg[ttb_pkg::NUM_W-1])
            den_mag = ttb_pkg::ABS_W'(-det_reg);
        else
            den_mag = ttb_pkg::ABS_W'(det_reg);
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        ttb_div_lane u_tan
        (
            .clk     (clk),
            .load    (lane_load),
            .step    (lane_step),
            .num     (tnum_reg[g]),
            .den_neg (det_reg[ttb_pkg::NUM_W-1]),
            .den     (den_mag),
            .result  (tan_res[g])
        );

        ttb_div_lane u_bit
        (
            .clk     (clk),
            .load    (lane_load),
            .step    (lane_step),
            .num     (bnum_reg[g]),
            .den_neg (det_reg[ttb_pkg::NUM_W-1]),
            .den     (den_mag),
            .result  (bit_res[g])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            deg_reg <= det_zero;
            for (int i = 0; i < 3; i++)
            begin
                tan_reg[i] <= det_zero ? '0 : tan_res[i];
                bit_reg[i] <= det_zero ? '0 : bit_res[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign tan_out   = tan_reg;
    assign bit_out   = bit_reg;
    assign deg_out   = deg_reg;

endmodule

FILE: tb/triangle_tangent_bitangent_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_tb: self-checking bench for the tangent block
// Streams vertices in groups of three and predicts one tangent/bitangent
// frame per triangle. The directed rows cover unit, saturating, degenerate
// and full-scale triangles. The random triangles are mesh-like, full-range,
// extreme, flat-UV, tiny-UV and flat-position, with random idling on both
// sides.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent_tb;

    localparam int IDLE_PCT    = 35;
    localparam int RAND_TRIS   = 593;
    localparam int DRAIN_EVERY = 150;
    localparam int QUIET_FIRST = 300;
    localparam int QUIET_LAST  = 380;
    localparam int SETTLE      = 60;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        ttb_pkg::coord_t x;
        ttb_pkg::coord_t y;
        ttb_pkg::coord_t z;
        logic [15:0]     u;
        logic [15:0]     v;
    } vert_t;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic               degen;
    } tri_frame_t;

    typedef struct packed {
        vert_t      vx;
        logic       typed;
        tri_frame_t frame;
    } stim_row_t;

    typedef enum
    {
        TRI_MESH,
        TRI_FULL,
        TRI_EXTREME,
        TRI_FLAT_UV,
        TRI_TINY_UV,
        TRI_FLAT_POS
    } tri_kind_t;

    localparam tri_frame_t FRAME_NONE  = '0;
    localparam tri_frame_t FRAME_DEGEN = {192'd0, 1'b1};
    localparam tri_frame_t FRAME_SAT   = {ttb_pkg::OUT_MAX, ttb_pkg::OUT_MIN, 128'd0, 1'b0};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic signed [15:0] pos_z = '0;
    logic [15:0]        tex_u = '0;
    logic [15:0]        tex_v = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;

    // typed expectation that travels with the vertex being offered
    logic               cur_typed = 1'b0;
    tri_frame_t         cur_frame = '0;
    logic               quiet = 1'b0;

    vert_t              corner_store [2];
    int                 corner_idx = 0;
    tri_frame_t         expected_frames [$];
    stim_row_t          directed_rows [$];

    int                 fail_count = 0;
    int                 vertices_taken = 0;
    int                 frames_checked = 0;
    int                 degen_seen = 0;
    int                 sat_seen = 0;
    int                 cycle_count = 0;

    string field_names [7] = '{"tangent_x", "tangent_y", "tangent_z",
                               "bitangent_x", "bitangent_y", "bitangent_z",
                               "degenerate"};

    triangle_tangent_bitangent uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tangent_x   (tangent_x),
        .tangent_y   (tangent_y),
        .tangent_z   (tangent_z),
        .bitangent_x (bitangent_x),
        .bitangent_y (bitangent_y),
        .bitangent_z (bitangent_z),
        .degenerate  (degenerate)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // frame predictor
    // ------------------------------------------------------------------
    function automatic longint axis_of(input vert_t cv, input int axis);
        case (axis)
            0:       return longint'(cv.x);
            1:       return longint'(cv.y);
            default: return longint'(cv.z);
        endcase
    endfunction

    // num * 2^(3+F) / den, rounded half away from zero, clamped to 32 bits
    function automatic logic [31:0] fixed_quot(input longint num, input longint den);
        logic              neg;
        longint unsigned   mag;
        longint unsigned   dmag;
        longint unsigned   q;
        neg  = (num < 0) != (den < 0);
        mag  = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        mag  = mag << (3 + ttb_pkg::OUT_FRAC_BITS);
        q    = (mag * 2 + dmag) / (dmag * 2);
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return -q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    // returns 1 when this vertex closes a triangle
    function automatic logic predict_frame(input vert_t cv, output tri_frame_t fr);
        longint      e1 [3];
        longint      e2 [3];
        logic [31:0] tq [3];
        logic [31:0] bq [3];
        longint      du1;
        longint      dv1;
        longint      du2;
        longint      dv2;
        longint      det;
        fr = '0;
        if (corner_idx < 2)
        begin
            corner_store[corner_idx] = cv;
            corner_idx++;
            return 1'b0;
        end
        corner_idx = 0;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = axis_of(corner_store[0], i) - axis_of(corner_store[1], i);
            e2[i] = axis_of(corner_store[0], i) - axis_of(cv, i);
        end
        du1 = longint'(corner_store[0].u) - longint'(corner_store[1].u);
        dv1 = longint'(corner_store[0].v) - longint'(corner_store[1].v);
        du2 = longint'(corner_store[0].u) - longint'(cv.u);
        dv2 = longint'(corner_store[0].v) - longint'(cv.v);
        det = du1 * dv2 - dv1 * du2;
        if (det == 0)
        begin
            fr.degen = 1'b1;
            return 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            tq[i] = fixed_quot(dv2 * e1[i] - dv1 * e2[i], det);
            bq[i] = fixed_quot(du1 * e2[i] - du2 * e1[i], det);
        end
        fr.tx = tq[0];
        fr.ty = tq[1];
        fr.tz = tq[2];
        fr.bx = bq[0];
        fr.by = bq[1];
        fr.bz = bq[2];
        return 1'b1;
    endfunction

    function automatic logic [31:0] frame_field(input tri_frame_t fr, input int k);
        case (k)
            0:       return fr.tx;
            1:       return fr.ty;
            2:       return fr.tz;
            3:       return fr.bx;
            4:       return fr.by;
            5:       return fr.bz;
            default: return {31'd0, fr.degen};
        endcase
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // checking: results first, then the vertex taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_and_predict
        tri_frame_t got;
        tri_frame_t want;
        tri_frame_t pred;
        logic       sat;
        if (out_valid && out_ready)
        begin
            got = {tangent_x, tangent_y, tangent_z,
                   bitangent_x, bitangent_y, bitangent_z, degenerate};
            if (expected_frames.size() == 0)
                report_failure($sformatf("result with no frame waiting: %h", got));
            else
            begin
                want = expected_frames.pop_front();
                frames_checked++;
                sat = 1'b0;
                for (int k = 0; k < 7; k++)
                begin
                    if (frame_field(got, k) !== frame_field(want, k))
                        report_failure($sformatf("frame %0d %s: expected %h, got %h",
                            frames_checked, field_names[k],
                            frame_field(want, k), frame_field(got, k)));
                    if (k < 6 && (frame_field(want, k) == ttb_pkg::OUT_MAX ||
                                  frame_field(want, k) == ttb_pkg::OUT_MIN))
                        sat = 1'b1;
                end
                if (want.degen)
                    degen_seen++;
                else if (sat)
                    sat_seen++;
            end
        end
        if (in_valid && in_ready)
        begin
            vertices_taken++;
            if (predict_frame({pos_x, pos_y, pos_z, tex_u, tex_v}, pred))
                expected_frames.insert(expected_frames.size(),
                                       cur_typed ? cur_frame : pred);
        end
    end

    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycle_count, expected_frames.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_row(input int x, input int y, input int z, input int u,
                           input int v, input logic typed, input tri_frame_t fr);
        stim_row_t row;
        row.vx.x  = 16'(x);
        row.vx.y  = 16'(y);
        row.vx.z  = 16'(z);
        row.vx.u  = 16'(u);
        row.vx.v  = 16'(v);
        row.typed = typed;
        row.frame = fr;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // offers one vertex and returns at the edge of its transfer
    task automatic send_vertex(input vert_t cv, input logic typed, input tri_frame_t fr);
        if (!quiet)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid  <= 1'b1;
        pos_x     <= cv.x;
        pos_y     <= cv.y;
        pos_z     <= cv.z;
        tex_u     <= cv.u;
        tex_v     <= cv.v;
        cur_typed <= typed;
        cur_frame <= fr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_frames();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_frames.size() != 0);
    endtask

    function automatic logic [15:0] jitter(input int span);
        return 16'($urandom_range(0, 2 * span - 1)) - 16'(span);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic vert_t rand_vertex();
        vert_t cv;
        cv.x = 16'($urandom);
        cv.y = 16'($urandom);
        cv.z = 16'($urandom);
        cv.u = 16'($urandom);
        cv.v = 16'($urandom);
        return cv;
    endfunction

    function automatic vert_t make_corner(input tri_kind_t kind, input vert_t base,
                                          input int c, input logic [15:0] su,
                                          input logic [15:0] sv);
        vert_t cv;
        cv = rand_vertex();
        case (kind)
            TRI_MESH:
            begin
                cv.x = base.x + jitter(2048);
                cv.y = base.y + jitter(2048);
                cv.z = base.z + jitter(2048);
                cv.u = base.u + jitter(4096);
                cv.v = base.v + jitter(4096);
            end
            TRI_EXTREME:
            begin
                cv.x = pick_extreme();
                cv.y = pick_extreme();
                cv.z = pick_extreme();
                cv.u = pick_extreme();
                cv.v = pick_extreme();
            end
            TRI_FLAT_UV:
            begin
                // corners step along one UV line, so det is zero unless it wraps
                cv.x = base.x + jitter(4096);
                cv.y = base.y + jitter(4096);
                cv.z = base.z + jitter(4096);
                cv.u = base.u + 16'(c) * su;
                cv.v = base.v + 16'(c) * sv;
            end
            TRI_TINY_UV:
            begin
                cv.u = base.u + jitter(2);
                cv.v = base.v + jitter(2);
            end
            TRI_FLAT_POS:
            begin
                cv.x = base.x;
                cv.y = base.y;
                cv.z = base.z;
                cv.u = base.u + jitter(4096);
                cv.v = base.v + jitter(4096);
            end
            default: ;
        endcase
        return cv;
    endfunction

    initial
    begin : stimulus
        vert_t       base;
        tri_kind_t   kind;
        int          pick;
        logic [15:0] su;
        logic [15:0] sv;

        // unit triangle: tangent along x, bitangent along y
        add_row(0, 0, 0, 32768, 32768, 1'b0, FRAME_NONE);
        add_row(-4096, 0, 0, 0, 32768, 1'b0, FRAME_NONE);
        add_row(0, -4096, 0, 32768, 0, 1'b0, FRAME_NONE);
        // full-scale edges over a one-LSB det: tangent clamps both ways
        add_row(32767, -32768, 0, 1, 1, 1'b0, FRAME_NONE);
        add_row(-32768, 32767, 0, 0, 1, 1'b0, FRAME_NONE);
        add_row(32767, -32768, 0, 1, 0, 1'b1, FRAME_SAT);
        // all corners identical
        add_row(0, 0, 0, 0, 0, 1'b0, FRAME_NONE);
        add_row(0, 0, 0, 0, 0, 1'b0, FRAME_NONE);
        add_row(0, 0, 0, 0, 0, 1'b1, FRAME_DEGEN);
        // extreme positions, one shared UV at full scale
        add_row(32767, 32767, 32767, 65535, 65535, 1'b0, FRAME_NONE);
        add_row(-32768, -32768, -32768, 65535, 65535, 1'b0, FRAME_NONE);
        add_row(32767, -32768, 0, 65535, 65535, 1'b1, FRAME_DEGEN);
        // collinear UVs with nonzero deltas
        add_row(100, 200, 300, 0, 0, 1'b0, FRAME_NONE);
        add_row(-100, 50, 7, 65535, 65535, 1'b0, FRAME_NONE);
        add_row(4000, -4000, 12, 32768, 32768, 1'b1, FRAME_DEGEN);
        // field extremes mixed across corners
        add_row(-32768, 32767, -32768, 65535, 0, 1'b0, FRAME_NONE);
        add_row(32767, -32768, 32767, 0, 65535, 1'b0, FRAME_NONE);
        add_row(-32768, -32768, 32767, 0, 0, 1'b0, FRAME_NONE);
        // negative det: clamped tangent, small negative bitangent
        add_row(32767, 0, -32768, 1, 0, 1'b0, FRAME_NONE);
        add_row(-32768, 0, 32767, 0, 0, 1'b0, FRAME_NONE);
        add_row(32766, 0, -32768, 1, 1, 1'b0, FRAME_NONE);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_vertex(directed_rows[i].vx, directed_rows[i].typed, directed_rows[i].frame);
        drain_frames();

        for (int t = 0; t < RAND_TRIS; t++)
        begin
            if (t == QUIET_FIRST)
                quiet <= 1'b1;
            else if (t == QUIET_LAST)
                quiet <= 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                kind = TRI_MESH;
            else if (pick < 60)
                kind = TRI_FULL;
            else if (pick < 70)
                kind = TRI_EXTREME;
            else if (pick < 80)
                kind = TRI_FLAT_UV;
            else if (pick < 92)
                kind = TRI_TINY_UV;
            else
                kind = TRI_FLAT_POS;
            base = rand_vertex();
            su = ($urandom_range(0, 3) == 0) ? 16'd0 : jitter(8192);
            sv = ($urandom_range(0, 3) == 0) ? 16'd0 : jitter(8192);
            for (int c = 0; c < 3; c++)
                send_vertex(make_corner(kind, base, c, su, sv), 1'b0, FRAME_NONE);
            if (t % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_frames();
        end

        // two corners of an unfinished triangle: no result may follow
        send_vertex(rand_vertex(), 1'b0, FRAME_NONE);
        send_vertex(rand_vertex(), 1'b0, FRAME_NONE);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_frames.size() != 0);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d vertex transfers and %0d triangle frames (%0d degenerate, %0d clamped)",
                 vertices_taken, frames_checked, degen_seen, sat_seen);
        $display("%0d failures over %0d cycles", fail_count, cycle_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
